/* rtl/urb_pkg.sv */
// Shared types and constants for the UART ring buffer engine.
package urb_pkg;

    // Operation codes carried in the opcode field.
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_GET   = 2'd1;
    localparam logic [1:0] OP_EVENT = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    // Result codes.
    localparam logic [1:0] RC_OK    = 2'd0;
    localparam logic [1:0] RC_FULL  = 2'd1;
    localparam logic [1:0] RC_EMPTY = 2'd2;

    // Event counter indexes.
    localparam int NUM_CNT = 6;
    localparam logic [2:0] CNT_ORE    = 3'd0;
    localparam logic [2:0] CNT_NOISE  = 3'd1;
    localparam logic [2:0] CNT_FRAME  = 3'd2;
    localparam logic [2:0] CNT_PARITY = 3'd3;
    localparam logic [2:0] CNT_TX_OVR = 3'd4;
    localparam logic [2:0] CNT_RX_OVR = 3'd5;

    // Command beat.
    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] put_byte;
        logic [7:0] received_byte;
        logic       rx_not_empty;
        logic       tx_empty;
        logic       overrun_flag;
        logic       noise_flag;
        logic       framing_flag;
        logic       parity_flag;
        logic [2:0] counter_index;
    } in_t;

    // Result beat.
    typedef struct packed {
        logic [1:0]  result_code;
        logic [7:0]  got_byte;
        logic [7:0]  transmit_byte;
        logic        transmit_valid;
        logic        rx_flush;
        logic        tx_irq_enabled;
        logic [15:0] counter_value;
    } out_t;

    // Requests from the control logic to the counter bank.
    typedef struct packed {
        logic [NUM_CNT-1:0] inc;
        logic [2:0]         idx;
    } cnt_req_t;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } state_t;

endpackage

/* rtl/urb_ring_mem.sv */
// Synchronous byte memory holding one ring, one write and one read port.
module urb_ring_mem #(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/urb_counters.sv */
// Bank of six saturating 16-bit event counters with a selectable read.
module urb_counters (
    input  logic              clk,
    input  logic              rst_n,
    input  urb_pkg::cnt_req_t req,
    output logic [15:0]       value
);

    logic [15:0] cnt_reg  [urb_pkg::NUM_CNT];
    logic [15:0] cnt_next [urb_pkg::NUM_CNT];

    // Each counter steps by one when asked and stops at its maximum.
    always_comb
    begin
        for (int i = 0; i < urb_pkg::NUM_CNT; i++)
        begin
            cnt_next[i] = cnt_reg[i];
            if (req.inc[i] && (cnt_reg[i] != 16'hFFFF))
            begin
                cnt_next[i] = cnt_reg[i] + 16'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < urb_pkg::NUM_CNT; i++)
            begin
                cnt_reg[i] <= '0;
            end
        end
        else
        begin
            for (int i = 0; i < urb_pkg::NUM_CNT; i++)
            begin
                cnt_reg[i] <= cnt_next[i];
            end
        end
    end

    // Read select; indexes past the last counter read as zero.
    always_comb
    begin
        case (req.idx)
            urb_pkg::CNT_ORE:    value = cnt_reg[0];
            urb_pkg::CNT_NOISE:  value = cnt_reg[1];
            urb_pkg::CNT_FRAME:  value = cnt_reg[2];
            urb_pkg::CNT_PARITY: value = cnt_reg[3];
            urb_pkg::CNT_TX_OVR: value = cnt_reg[4];
            urb_pkg::CNT_RX_OVR: value = cnt_reg[5];
            default:             value = 16'd0;
        endcase
    end

endmodule

/* rtl/uart_ring_buffer_engine_unit.sv */
// Top level of the UART ring buffer engine: sequencer, ring pointers and result register.
//
// In the cycle where start is seen with busy low the command is captured and both ring
// memories are read at their tail pointers; in the following cycle (busy high) the read
// data comes back, the pointers, the interrupt enable and the counters are updated, the
// ring memory is written for a put or a stored receive byte, and the result is registered.
// done is high for exactly one cycle after that, and busy is already low in that cycle,
// so a new command can be accepted while the previous result is shown. The receiver
// cannot stall results, so a result must be taken in its done cycle. Ring entries hold
// no reset value; only entries written by earlier commands are ever used in a result.
module uart_ring_buffer_engine_unit #(
    parameter int TX_RING_DEPTH = 256,
    parameter int RX_RING_DEPTH = 256
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  urb_pkg::in_t  item,
    output logic          done,
    output urb_pkg::out_t result
);

    localparam int TAW = $clog2(TX_RING_DEPTH);
    localparam int RAW = $clog2(RX_RING_DEPTH);
    localparam logic [TAW-1:0] TX_LAST = TAW'(TX_RING_DEPTH - 1);
    localparam logic [RAW-1:0] RX_LAST = RAW'(RX_RING_DEPTH - 1);

    urb_pkg::state_t state_reg, state_next;
    urb_pkg::in_t    cmd_reg;
    urb_pkg::out_t   result_reg, result_next;
    logic            done_reg, done_next;

    logic [TAW-1:0] tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [RAW-1:0] rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic           irq_reg, irq_next;

    logic [TAW-1:0] tx_head_adv, tx_tail_adv;
    logic [RAW-1:0] rx_head_adv, rx_tail_adv;

    logic           accept, exec;
    logic           tx_wr_en, rx_wr_en;
    logic [TAW-1:0] tx_wr_addr;
    logic [RAW-1:0] rx_wr_addr;
    logic [7:0]     tx_wr_data, rx_wr_data;
    logic [7:0]     tx_rd_data, rx_rd_data;

    urb_pkg::cnt_req_t cnt_req;
    logic [15:0]       cnt_value;

    assign accept = start && (state_reg == urb_pkg::ST_IDLE);
    assign exec   = (state_reg == urb_pkg::ST_EXEC);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            urb_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    state_next = urb_pkg::ST_EXEC;
                end
            end
            urb_pkg::ST_EXEC: state_next = urb_pkg::ST_IDLE;
            default:          state_next = urb_pkg::ST_IDLE;
        endcase
    end

    // State outputs.
    always_comb
    begin
        case (state_reg)
            urb_pkg::ST_EXEC: busy = 1'b1;
            default:          busy = 1'b0;
        endcase
    end

    // Ring storage; reads are issued at the tail pointers when a command is taken.
    urb_ring_mem #(
        .DEPTH (TX_RING_DEPTH),
        .AW    (TAW)
    ) u_tx_mem (
        .clk     (clk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (tx_wr_data),
        .rd_en   (accept),
        .rd_addr (tx_tail_reg),
        .rd_data (tx_rd_data)
    );

    urb_ring_mem #(
        .DEPTH (RX_RING_DEPTH),
        .AW    (RAW)
    ) u_rx_mem (
        .clk     (clk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (rx_wr_data),
        .rd_en   (accept),
        .rd_addr (rx_tail_reg),
        .rd_data (rx_rd_data)
    );

    urb_counters u_counters (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cnt_req),
        .value (cnt_value)
    );

    // Pointer increments with wrap at the ring depth.
    assign tx_head_adv = (tx_head_reg == TX_LAST) ? '0 : tx_head_reg + TAW'(1);
    assign tx_tail_adv = (tx_tail_reg == TX_LAST) ? '0 : tx_tail_reg + TAW'(1);
    assign rx_head_adv = (rx_head_reg == RX_LAST) ? '0 : rx_head_reg + RAW'(1);
    assign rx_tail_adv = (rx_tail_reg == RX_LAST) ? '0 : rx_tail_reg + RAW'(1);

    assign tx_wr_addr = tx_head_reg;
    assign rx_wr_addr = rx_head_reg;
    assign tx_wr_data = cmd_reg.put_byte;
    assign rx_wr_data = cmd_reg.received_byte;

    // Command execution in the cycle after capture, when the read data is back.
    always_comb
    begin
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        irq_next     = irq_reg;
        tx_wr_en     = 1'b0;
        rx_wr_en     = 1'b0;
        cnt_req.inc  = '0;
        cnt_req.idx  = cmd_reg.counter_index;
        result_next  = '0;
        done_next    = exec;

        if (exec)
        begin
            case (cmd_reg.opcode)
                urb_pkg::OP_PUT:
                begin
                    if (tx_head_adv == tx_tail_reg)
                    begin
                        cnt_req.inc[urb_pkg::CNT_TX_OVR] = 1'b1;
                        result_next.result_code = urb_pkg::RC_FULL;
                    end
                    else
                    begin
                        tx_wr_en     = 1'b1;
                        tx_head_next = tx_head_adv;
                        irq_next     = 1'b1;
                    end
                end
                urb_pkg::OP_GET:
                begin
                    if (rx_tail_reg == rx_head_reg)
                    begin
                        result_next.result_code = urb_pkg::RC_EMPTY;
                    end
                    else
                    begin
                        result_next.got_byte = rx_rd_data;
                        rx_tail_next = rx_tail_adv;
                    end
                end
                urb_pkg::OP_EVENT:
                begin
                    // Receive side first, then transmit, then the error flags.
                    if (cmd_reg.rx_not_empty)
                    begin
                        if (rx_head_adv == rx_tail_reg)
                        begin
                            cnt_req.inc[urb_pkg::CNT_RX_OVR] = 1'b1;
                            result_next.rx_flush = 1'b1;
                        end
                        else
                        begin
                            rx_wr_en     = 1'b1;
                            rx_head_next = rx_head_adv;
                        end
                    end
                    if (cmd_reg.tx_empty)
                    begin
                        if (tx_tail_reg == tx_head_reg)
                        begin
                            irq_next = 1'b0;
                        end
                        else
                        begin
                            result_next.transmit_byte  = tx_rd_data;
                            result_next.transmit_valid = 1'b1;
                            tx_tail_next = tx_tail_adv;
                        end
                    end
                    cnt_req.inc[urb_pkg::CNT_ORE]    = cmd_reg.overrun_flag;
                    cnt_req.inc[urb_pkg::CNT_NOISE]  = cmd_reg.noise_flag;
                    cnt_req.inc[urb_pkg::CNT_FRAME]  = cmd_reg.framing_flag;
                    cnt_req.inc[urb_pkg::CNT_PARITY] = cmd_reg.parity_flag;
                end
                urb_pkg::OP_READ:
                begin
                    result_next.counter_value = cnt_value;
                end
                default:
                begin
                    result_next.result_code = urb_pkg::RC_OK;
                end
            endcase
            result_next.tx_irq_enabled = irq_next;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= urb_pkg::ST_IDLE;
            done_reg    <= 1'b0;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            irq_reg     <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            done_reg    <= done_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            irq_reg     <= irq_next;
        end
    end

    // Payload registers: captured command and the result beat.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= item;
        end
        if (exec)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

/* rtl/urb_checker.sv */
// Port-level checks for the UART ring buffer engine, bound to the top level.
module urb_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          start,
    input logic          busy,
    input urb_pkg::in_t  item,
    input logic          done,
    input urb_pkg::out_t result
);

    // A taken command keeps the block busy for the following cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("command taken but block not busy next cycle");

    // The execute cycle lasts one cycle and is followed by exactly one result beat.
    a_busy_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("busy cycle not followed by a result beat");

    // A result beat only follows a busy cycle.
    a_done_past: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result beat without a preceding busy cycle");

    // A sent byte comes from an event, so fields of other commands stay zero.
    a_tx_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.transmit_valid) |->
            (result.got_byte == 8'd0 && result.counter_value == 16'd0 &&
             result.result_code == urb_pkg::RC_OK))
        else $error("transmit beat carries fields of another command");

    // A flushed receive byte never comes with a failure code.
    a_flush_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.rx_flush) |-> (result.result_code == urb_pkg::RC_OK))
        else $error("receive flush with a nonzero result code");

endmodule

bind uart_ring_buffer_engine_unit urb_checker u_urb_checker (.*);
